@@ design/lcts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_pkg
// Shared types and constants of the load cell tare and scale unit.
// ----------------------------------------------------------------------------
package lcts_pkg;

    localparam int RAW_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SUM_W      = 24;
    localparam int COUNT_W    = 8;
    localparam int GAIN_W     = 12;
    localparam int WEIGHT_W   = 25;
    localparam int FACTOR_W   = 5;
    localparam int SCALED_W   = DIFF_W + FACTOR_W;
    localparam int DIVD_W     = 33;
    localparam int DIVS_W     = GAIN_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [FACTOR_W-1:0] WEIGHT_FACTOR      = FACTOR_W'(25);
    localparam logic [COUNT_W-1:0]  CALIB_SAMPLES_RST  = COUNT_W'(40);
    localparam logic [GAIN_W-1:0]   GAIN_MULT_RST      = GAIN_W'(1010);
    localparam logic [GAIN_W-1:0]   GAIN_DIV_RST       = GAIN_W'(1000);

    // raw word layout
    localparam int RAW_NOT_READY_BIT = 31;
    localparam int RAW_SIGN_BIT      = 30;
    localparam int RAW_FIELD_MSB     = 29;
    localparam int RAW_FIELD_LSB     = 14;

    typedef enum logic [1:0] {
        REG_CALIB_SAMPLES = 2'd0,
        REG_GAIN_MULT     = 2'd1,
        REG_GAIN_DIV      = 2'd2
    } lcts_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } lcts_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] calib_samples;
        logic [GAIN_W-1:0]  gain_mult;
        logic [GAIN_W-1:0]  gain_div;
    } lcts_cfg_t;

    typedef struct packed {
        logic div_start;
        logic out_load;
    } lcts_ctl_t;

endpackage

@@ design/lcts_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts stream interfaces
// Valid/ready channels for converter words in and weight results out.
// ----------------------------------------------------------------------------
interface lcts_in_if;
    logic                            valid;
    logic                            ready;
    logic [lcts_pkg::RAW_W-1:0]      raw_word;
    logic                            tare_request;

    modport source (output valid, output raw_word, output tare_request, input ready);
    modport sink   (input valid, input raw_word, input tare_request, output ready);
endinterface

interface lcts_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  sample_valid;
    logic                                  calibrating;
    logic [lcts_pkg::COUNT_W-1:0]          calib_progress;
    logic signed [lcts_pkg::WEIGHT_W-1:0]  weight_grams;
    logic                                  tare_restarted;

    modport source (output valid, output sample_valid, output calibrating,
                    output calib_progress, output weight_grams, output tare_restarted,
                    input ready);
    modport sink   (input valid, input sample_valid, input calibrating,
                    input calib_progress, input weight_grams, input tare_restarted,
                    output ready);
endinterface

@@ design/lcts_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_cfg
// APB register bank holding sample count and gain correction settings.
// ----------------------------------------------------------------------------
module lcts_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcts_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcts_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcts_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lcts_pkg::lcts_cfg_t                 cfg
);

    lcts_pkg::lcts_cfg_t cfg_reg;
    lcts_pkg::lcts_cfg_t cfg_next;
    lcts_pkg::lcts_reg_t reg_sel;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_sel = lcts_pkg::lcts_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                lcts_pkg::REG_CALIB_SAMPLES:
                    cfg_next.calib_samples = pwdata[lcts_pkg::COUNT_W-1:0];
                lcts_pkg::REG_GAIN_MULT:
                    cfg_next.gain_mult = pwdata[lcts_pkg::GAIN_W-1:0];
                lcts_pkg::REG_GAIN_DIV:
                    cfg_next.gain_div = pwdata[lcts_pkg::GAIN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.calib_samples <= lcts_pkg::CALIB_SAMPLES_RST;
            cfg_reg.gain_mult     <= lcts_pkg::GAIN_MULT_RST;
            cfg_reg.gain_div      <= lcts_pkg::GAIN_DIV_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            lcts_pkg::REG_CALIB_SAMPLES:
                prdata = lcts_pkg::APB_DATA_W'(cfg_reg.calib_samples);
            lcts_pkg::REG_GAIN_MULT:
                prdata = lcts_pkg::APB_DATA_W'(cfg_reg.gain_mult);
            lcts_pkg::REG_GAIN_DIV:
                prdata = lcts_pkg::APB_DATA_W'(cfg_reg.gain_div);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ design/lcts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module lcts_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lcts_pkg::DIVD_W-1:0]       dividend,
    input  logic [lcts_pkg::DIVS_W-1:0]       divisor,
    output logic                              done,
    output logic [lcts_pkg::DIVD_W-1:0]       quotient
);

    localparam int DW = lcts_pkg::DIVD_W;
    localparam int SW = lcts_pkg::DIVS_W;
    localparam int CW = lcts_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [SW:0]   rem_shift;
    logic [SW:0]   rem_sub;
    logic          fits;

    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? rem_sub[SW-1:0] : rem_shift[SW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/load_cell_tare_and_scale_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_tare_and_scale_unit
// Tare averaging and gain scaling of raw load cell converter words.
//
// in_ch carries one converter word and a tare flag per transfer; out_ch
// returns one result per word. Registers sit on an APB port: calib_samples
// at 0x0, gain_mult at 0x4, gain_div at 0x8. The user must see that they
// are written only while idle; the block itself does not enforce it.
// One word is handled at a time: in_ch.ready is high only in the idle state.
// A not ready word or a calibration sample other than the last goes from
// the prep state straight to the output state, which loads the output
// register and returns to idle. A weighing sample passes ST_PREP, ST_MUL1,
// ST_MUL2, ST_DIV_GO and ST_DIV_WAIT, the last calibration sample skips the
// multiply states, and both go through the shared bit-serial divider.
// Results wait in an output register, so a stalled receiver holds at most
// one finished result; the next word is accepted meanwhile and is held at
// its end until the register frees up.
// Reset clears the offset, sum, count and sequencer and loads the register
// defaults (40, 1010, 1000).
// ----------------------------------------------------------------------------
module load_cell_tare_and_scale_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcts_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcts_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcts_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    lcts_in_if.sink                             in_ch,
    lcts_out_if.source                          out_ch
);

    localparam int SW = lcts_pkg::SAMPLE_W;
    localparam int DF = lcts_pkg::DIFF_W;
    localparam int UW = lcts_pkg::SUM_W;
    localparam int CW = lcts_pkg::COUNT_W;
    localparam int WW = lcts_pkg::WEIGHT_W;
    localparam int MW = lcts_pkg::DIVD_W;
    localparam logic [MW-1:0] POS_LIMIT = MW'((64'd1 << (WW - 1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIMIT = MW'(64'd1 << (WW - 1));

    lcts_pkg::lcts_cfg_t   cfg;
    lcts_pkg::lcts_state_t state_reg, state_next;
    lcts_pkg::lcts_ctl_t   ctl;

    logic                 in_fire;
    logic [lcts_pkg::RAW_W-1:0] raw_reg;
    logic                 tare_reg;

    logic signed [SW-1:0] offset_reg;
    logic signed [UW-1:0] sum_reg;
    logic [CW-1:0]        count_reg;

    logic [MW-1:0]        mag_reg;
    logic                 neg_reg;
    logic                 mode_offset_reg;

    logic                 res_valid_reg;
    logic                 res_calib_reg;
    logic [CW-1:0]        res_progress_reg;
    logic signed [WW-1:0] res_weight_reg;

    logic                 out_valid_reg;
    logic                 out_sample_valid_reg;
    logic                 out_calib_reg;
    logic [CW-1:0]        out_progress_reg;
    logic signed [WW-1:0] out_weight_reg;
    logic                 out_tare_reg;

    // item evaluation
    logic signed [DF-1:0] raw_field;
    logic signed [SW-1:0] sample;
    logic [CW-1:0]        count0;
    logic signed [UW-1:0] sum0;
    logic signed [UW-1:0] sum_new;
    logic [CW-1:0]        count_new;
    logic signed [DF-1:0] diff;
    logic                 not_ready;
    logic                 do_calib;
    logic                 last_calib;

    logic                 div_done;
    logic [MW-1:0]        div_q;
    logic [lcts_pkg::DIVS_W-1:0] div_divisor;
    logic [lcts_pkg::DIVS_W-1:0] gain_div_eff;
    logic [MW-1:0]        q_neg;

    lcts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign gain_div_eff = (cfg.gain_div == '0) ? lcts_pkg::DIVS_W'(1) : cfg.gain_div;
    assign div_divisor  = mode_offset_reg ? lcts_pkg::DIVS_W'(cfg.calib_samples)
                                          : gain_div_eff;

    lcts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (mag_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == lcts_pkg::ST_IDLE);

    // sample extraction with saturation to 16 bits
    assign raw_field = {raw_reg[lcts_pkg::RAW_SIGN_BIT],
                        raw_reg[lcts_pkg::RAW_FIELD_MSB:lcts_pkg::RAW_FIELD_LSB]};

    always_comb
    begin
        if (!raw_field[DF-1] && raw_field[DF-2])
            sample = {1'b0, {(SW-1){1'b1}}};
        else if (raw_field[DF-1] && !raw_field[DF-2])
            sample = {1'b1, {(SW-1){1'b0}}};
        else
            sample = raw_field[SW-1:0];
    end

    assign not_ready  = raw_reg[lcts_pkg::RAW_NOT_READY_BIT];
    assign count0     = tare_reg ? '0 : count_reg;
    assign sum0       = tare_reg ? '0 : sum_reg;
    assign sum_new    = sum0 + UW'(sample);
    assign count_new  = count0 + 1'b1;
    assign do_calib   = count0 < cfg.calib_samples;
    assign last_calib = count_new == cfg.calib_samples;
    assign diff       = DF'(sample) - DF'(offset_reg);
    assign q_neg      = -div_q;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcts_pkg::ST_IDLE:
                if (in_fire)
                    state_next = lcts_pkg::ST_PREP;
            lcts_pkg::ST_PREP:
                if (not_ready)
                    state_next = lcts_pkg::ST_OUT;
                else if (do_calib)
                    state_next = last_calib ? lcts_pkg::ST_DIV_GO : lcts_pkg::ST_OUT;
                else
                    state_next = lcts_pkg::ST_MUL1;
            lcts_pkg::ST_MUL1:
                state_next = lcts_pkg::ST_MUL2;
            lcts_pkg::ST_MUL2:
                state_next = lcts_pkg::ST_DIV_GO;
            lcts_pkg::ST_DIV_GO:
                state_next = lcts_pkg::ST_DIV_WAIT;
            lcts_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = lcts_pkg::ST_OUT;
            lcts_pkg::ST_OUT:
                if (ctl.out_load)
                    state_next = lcts_pkg::ST_IDLE;
            default:
                state_next = lcts_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl.div_start = 1'b0;
        ctl.out_load  = 1'b0;
        case (state_reg)
            lcts_pkg::ST_DIV_GO:
                ctl.div_start = 1'b1;
            lcts_pkg::ST_OUT:
                ctl.out_load = !out_valid_reg || out_ch.ready;
            default:
            begin
                ctl.div_start = 1'b0;
                ctl.out_load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lcts_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (state_reg == lcts_pkg::ST_PREP)
            begin
                if (!not_ready && do_calib)
                begin
                    sum_reg   <= sum_new;
                    count_reg <= count_new;
                end
                else
                begin
                    sum_reg   <= sum0;
                    count_reg <= count0;
                end
            end
            if (state_reg == lcts_pkg::ST_DIV_WAIT && div_done && mode_offset_reg)
                offset_reg <= neg_reg ? q_neg[SW-1:0] : div_q[SW-1:0];
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            raw_reg  <= in_ch.raw_word;
            tare_reg <= in_ch.tare_request;
        end
        case (state_reg)
            lcts_pkg::ST_PREP:
            begin
                res_valid_reg  <= !not_ready;
                res_calib_reg  <= !not_ready && do_calib;
                res_weight_reg <= '0;
                if (!not_ready && do_calib)
                begin
                    res_progress_reg <= count_new;
                    mode_offset_reg  <= 1'b1;
                    neg_reg          <= sum_new[UW-1];
                    mag_reg          <= MW'(sum_new[UW-1] ? -sum_new : sum_new);
                end
                else
                begin
                    res_progress_reg <= count0;
                    mode_offset_reg  <= 1'b0;
                    neg_reg          <= diff[DF-1];
                    mag_reg          <= MW'(diff[DF-1] ? -diff : diff);
                end
            end
            lcts_pkg::ST_MUL1:
                mag_reg <= MW'(mag_reg[DF-1:0] * lcts_pkg::WEIGHT_FACTOR);
            lcts_pkg::ST_MUL2:
                mag_reg <= MW'(mag_reg[lcts_pkg::SCALED_W-1:0] * cfg.gain_mult);
            lcts_pkg::ST_DIV_WAIT:
                if (div_done && !mode_offset_reg)
                begin
                    if (neg_reg)
                        res_weight_reg <= (div_q > NEG_LIMIT) ? NEG_LIMIT[WW-1:0]
                                                              : q_neg[WW-1:0];
                    else
                        res_weight_reg <= (div_q > POS_LIMIT) ? POS_LIMIT[WW-1:0]
                                                              : div_q[WW-1:0];
                end
            default:
                mag_reg <= mag_reg;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_sample_valid_reg <= res_valid_reg;
            out_calib_reg        <= res_calib_reg;
            out_progress_reg     <= res_progress_reg;
            out_weight_reg       <= res_weight_reg;
            out_tare_reg         <= tare_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sample_valid   = out_sample_valid_reg;
    assign out_ch.calibrating    = out_calib_reg;
    assign out_ch.calib_progress = out_progress_reg;
    assign out_ch.weight_grams   = out_weight_reg;
    assign out_ch.tare_restarted = out_tare_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == lcts_pkg::ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_fire_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == lcts_pkg::ST_PREP)
        else $error("accepted word did not start evaluation");

    a_calib_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_calib_reg) |-> (out_progress_reg != '0 && out_sample_valid_reg))
        else $error("calibration result without progress");

    a_calib_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_calib_reg || !out_sample_valid_reg)) |-> out_weight_reg == '0)
        else $error("nonzero weight on a non weighing result");

endmodule

@@ test/lcts_weight_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcts_weight_checker
// Watches the register port and both streams of the load cell tare and scale
// unit, predicts one result per accepted converter word from its own copy of
// the calibration state and register settings, and compares every result
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lcts_weight_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [lcts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcts_pkg::APB_DATA_W-1:0] pwdata,
    lcts_in_if                              in_ch,
    lcts_out_if                             out_ch,
    output int                              pending,
    output int                              fail_count
);

    localparam longint WEIGHT_TOP    = 2 ** (lcts_pkg::WEIGHT_W - 1) - 1;
    localparam longint WEIGHT_BOTTOM = -(2 ** (lcts_pkg::WEIGHT_W - 1));
    localparam int     SAMPLE_TOP    = 2 ** (lcts_pkg::SAMPLE_W - 1) - 1;
    localparam int     SAMPLE_BOTTOM = -(2 ** (lcts_pkg::SAMPLE_W - 1));

    typedef struct packed {
        logic                                 sample_valid;
        logic                                 calibrating;
        logic [lcts_pkg::COUNT_W-1:0]         calib_progress;
        logic signed [lcts_pkg::WEIGHT_W-1:0] weight_grams;
        logic                                 tare_restarted;
    } weight_result_t;

    lcts_pkg::lcts_cfg_t                  cfg;
    logic signed [lcts_pkg::SAMPLE_W-1:0] tare_offset_q;
    int                                   calib_sum_q;
    logic [lcts_pkg::COUNT_W-1:0]         calib_count_q;
    weight_result_t                       weight_results_q[$];

    function automatic weight_result_t advance_scale(
        input logic [lcts_pkg::RAW_W-1:0] raw, input logic tare);
        weight_result_t                       r;
        logic signed [lcts_pkg::SAMPLE_W-1:0] s;
        int                                   v;
        longint                               diff;
        longint                               divisor;
        longint                               w;
        r = '0;
        r.tare_restarted = tare;
        if (tare)
        begin
            calib_count_q = '0;
            calib_sum_q   = 0;
        end
        if (!raw[lcts_pkg::RAW_NOT_READY_BIT])
        begin
            v = int'(raw[lcts_pkg::RAW_FIELD_MSB:lcts_pkg::RAW_FIELD_LSB]);
            if (raw[lcts_pkg::RAW_SIGN_BIT])
                v -= 65536;
            if (v > SAMPLE_TOP)
                v = SAMPLE_TOP;
            if (v < SAMPLE_BOTTOM)
                v = SAMPLE_BOTTOM;
            s = v[lcts_pkg::SAMPLE_W-1:0];
            r.sample_valid = 1'b1;
            if (calib_count_q < cfg.calib_samples)
            begin
                calib_sum_q   += int'(s);
                calib_count_q += 1'b1;
                r.calibrating  = 1'b1;
                if (calib_count_q == cfg.calib_samples)
                    tare_offset_q = lcts_pkg::SAMPLE_W'(calib_sum_q
                                                        / int'(cfg.calib_samples));
            end
            else
            begin
                diff    = longint'(s) - longint'(tare_offset_q);
                divisor = (cfg.gain_div == '0) ? 64'sd1 : longint'(cfg.gain_div);
                w = diff * longint'(lcts_pkg::WEIGHT_FACTOR) * longint'(cfg.gain_mult)
                    / divisor;
                if (w > WEIGHT_TOP)
                    w = WEIGHT_TOP;
                if (w < WEIGHT_BOTTOM)
                    w = WEIGHT_BOTTOM;
                r.weight_grams = w[lcts_pkg::WEIGHT_W-1:0];
            end
        end
        r.calib_progress = calib_count_q;
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected %0d actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        weight_result_t want;
        if (!rst_n)
        begin
            cfg           = '{lcts_pkg::CALIB_SAMPLES_RST, lcts_pkg::GAIN_MULT_RST,
                              lcts_pkg::GAIN_DIV_RST};
            tare_offset_q = '0;
            calib_sum_q   = 0;
            calib_count_q = '0;
            fail_count    = 0;
            weight_results_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (lcts_pkg::lcts_reg_t'(paddr[lcts_pkg::APB_ADDR_W-1:2]))
                    lcts_pkg::REG_CALIB_SAMPLES:
                        cfg.calib_samples = pwdata[lcts_pkg::COUNT_W-1:0];
                    lcts_pkg::REG_GAIN_MULT:
                        cfg.gain_mult     = pwdata[lcts_pkg::GAIN_W-1:0];
                    lcts_pkg::REG_GAIN_DIV:
                        cfg.gain_div      = pwdata[lcts_pkg::GAIN_W-1:0];
                    default:           ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (weight_results_q.size() == 0)
                begin
                    fail_count++;
                    $error("result transfer with no word outstanding");
                end
                else
                begin
                    want = weight_results_q.pop_front();
                    compare_field("sample_valid", want.sample_valid, out_ch.sample_valid);
                    compare_field("calibrating", want.calibrating, out_ch.calibrating);
                    compare_field("calib_progress", want.calib_progress,
                                  out_ch.calib_progress);
                    compare_field("weight_grams", $signed(want.weight_grams),
                                  $signed(out_ch.weight_grams));
                    compare_field("tare_restarted", want.tare_restarted,
                                  out_ch.tare_restarted);
                end
            end
            if (in_ch.valid && in_ch.ready)
                weight_results_q.push_back(advance_scale(in_ch.raw_word, in_ch.tare_request));
            pending <= weight_results_q.size();
        end
    end

endmodule

@@ test/tb_load_cell_tare_and_scale_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_cell_tare_and_scale_unit
// Drives converter words with tare requests into the load cell unit, first a
// directed set around calibration, sign, saturation and register corner
// settings, then random words over a series of register settings, with
// random idling on both streams and two long receiver stalls.
// ----------------------------------------------------------------------------
module tb_load_cell_tare_and_scale_unit;

    localparam int IDLE_PCT       = 17;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 50;

    logic                            clk   = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcts_pkg::APB_ADDR_W-1:0] paddr;
    logic [lcts_pkg::APB_DATA_W-1:0] pwdata;
    logic [lcts_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    int                              pending;
    int                              fail_count;
    int                              words_sent  = 0;
    int                              idle_cycles = 0;

    lcts_in_if  in_ch ();
    lcts_out_if out_ch ();

    load_cell_tare_and_scale_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    lcts_weight_checker u_weight_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, two long hold-offs, one stretch always ready
    initial
    begin
        int taken;
        int hold_left;
        int held_at;
        taken     = 0;
        hold_left = 0;
        held_at   = -1;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                taken++;
            if ((taken == 80 || taken == 450) && held_at != taken)
            begin
                hold_left = HOLD_CYCLES;
                held_at   = taken;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (taken >= 600 && taken < 720)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_word(input logic [lcts_pkg::RAW_W-1:0] raw, input logic tare);
        while (!(words_sent >= 300 && words_sent < 420) &&
               $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.raw_word     <= raw;
        in_ch.tare_request <= tare;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input lcts_pkg::lcts_reg_t r,
                             input logic [lcts_pkg::APB_DATA_W-1:0] value);
        wait_results_done();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lcts_pkg::APB_ADDR_W'({r, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int samples, input int mult, input int div);
        write_reg(lcts_pkg::REG_CALIB_SAMPLES, samples);
        write_reg(lcts_pkg::REG_GAIN_MULT, mult);
        write_reg(lcts_pkg::REG_GAIN_DIV, div);
    endtask

    function automatic logic [lcts_pkg::RAW_W-1:0] random_word();
        logic [lcts_pkg::RAW_W-1:0] w;
        int                         pick;
        int                         s;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            w[lcts_pkg::RAW_NOT_READY_BIT] = 1'b1;
        else
        begin
            w[lcts_pkg::RAW_NOT_READY_BIT] = 1'b0;
            // small readings around zero, from -400 to 400
            if (pick < 55)
            begin
                s = $urandom_range(0, 800);
                s -= 400;
                w[lcts_pkg::RAW_SIGN_BIT] = (s < 0);
                w[lcts_pkg::RAW_FIELD_MSB:lcts_pkg::RAW_FIELD_LSB] = s[15:0];
            end
        end
        return w;
    endfunction

    initial
    begin
        int n;
        int tare_pct;
        in_ch.valid        <= 1'b0;
        in_ch.raw_word     <= '0;
        in_ch.tare_request <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration, sign and truncation corners
        write_reg(lcts_pkg::REG_CALIB_SAMPLES, 3);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h3FFF_FFFF, 1'b0);
        send_word(32'h4000_0000, 1'b0);
        send_word(32'h7FFF_C000, 1'b0);
        send_word(32'h3FFF_FFFF, 1'b0);
        send_word(32'h4000_0000, 1'b0);
        send_word(32'h0000_3FFF, 1'b0);
        send_word(32'h2000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        // tare keeps the old offset until the new average is complete
        send_word(32'h0001_0000, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0001_4000, 1'b0);
        send_word(32'h0001_8000, 1'b0);
        send_word(32'h0001_C000, 1'b0);
        // weight saturation
        write_reg(lcts_pkg::REG_GAIN_MULT, 4095);
        write_reg(lcts_pkg::REG_GAIN_DIV, 1);
        send_word(32'h3FFF_FFFF, 1'b0);
        send_word(32'h4000_0000, 1'b0);
        // zero multiplier, zero divisor
        write_reg(lcts_pkg::REG_GAIN_MULT, 0);
        write_reg(lcts_pkg::REG_GAIN_DIV, 0);
        send_word(32'h0001_0000, 1'b0);
        write_reg(lcts_pkg::REG_GAIN_MULT, 7);
        send_word(32'h0003_0000, 1'b0);
        // no calibration at all, then a count left above a lowered setting
        write_reg(lcts_pkg::REG_CALIB_SAMPLES, 0);
        send_word(32'h0001_0000, 1'b1);
        write_reg(lcts_pkg::REG_CALIB_SAMPLES, 10);
        send_word(32'h0000_4000, 1'b0);
        send_word(32'h0000_8000, 1'b0);
        write_reg(lcts_pkg::REG_CALIB_SAMPLES, 1);
        send_word(32'h0000_C000, 1'b0);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    apply_setting(40, 1010, 1000);
                    n = 130;
                    tare_pct = 2;
                end
                1:
                begin
                    apply_setting(255, $urandom_range(0, 4095), $urandom_range(1, 4095));
                    n = 320;
                    tare_pct = 0;
                end
                2:
                begin
                    apply_setting(1, 4095, 1);
                    n = 70;
                    tare_pct = 5;
                end
                3:
                begin
                    apply_setting($urandom_range(1, 12), $urandom_range(0, 4095),
                                  $urandom_range(1, 4095));
                    n = 110;
                    tare_pct = 6;
                end
                4:
                begin
                    apply_setting(0, $urandom_range(0, 4095), 0);
                    n = 50;
                    tare_pct = 5;
                end
                5:
                begin
                    apply_setting($urandom_range(2, 8), 0, 4095);
                    n = 50;
                    tare_pct = 8;
                end
                default:
                begin
                    apply_setting($urandom_range(1, 6), 4095, 4095);
                    n = 100;
                    tare_pct = 5;
                end
            endcase
            repeat (n)
                send_word(random_word(), $urandom_range(0, 99) < tare_pct);
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
